// File: hw/rtl/assert_macros.svh
// Assertion helper macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge once reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/pafk_pkg.sv
// ----------------------------------------------------------------------------
// pafk_pkg
// Shared types and constants for the planar arm kinematics block.
// ----------------------------------------------------------------------------
package pafk_pkg;

    localparam int MaxLinks    = 16;
    localparam int AngleBits   = 16;
    localparam int CordicSteps = 16;
    localparam int StepBits    = $clog2(CordicSteps);
    localparam int CntBits     = $clog2(MaxLinks);

    // Datapath width of the rotator: magnitude (22 bit) times gain needs ~54 bits.
    localparam int DW = 56;

    localparam logic [31:0] InvGain = 32'd1304065748;

    localparam logic signed [21:0] RunMax = 22'sd2097151;
    localparam logic signed [21:0] RunMin = -22'sd2097152;
    localparam logic signed [20:0] OutMax = 21'sd1048575;
    localparam logic signed [20:0] OutMin = -21'sd1048576;

    localparam logic [0:0] RegLinkLength   = 1'b0;
    localparam logic [0:0] RegBaseRotation = 1'b1;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h20000000;
            5'd1:  return 32'h12E4051E;
            5'd2:  return 32'h09FB385B;
            5'd3:  return 32'h051111D4;
            5'd4:  return 32'h028B0D43;
            5'd5:  return 32'h0145D7E1;
            5'd6:  return 32'h00A2F61E;
            5'd7:  return 32'h00517C55;
            5'd8:  return 32'h0028BE53;
            5'd9:  return 32'h00145F2F;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2FA;
            5'd15: return 32'h0000517D;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A30;
            5'd19: return 32'h00000518;
            5'd20: return 32'h0000028C;
            5'd21: return 32'h00000146;
            5'd22: return 32'h000000A3;
            default: return 32'h00000051;
        endcase
    endfunction

    // Handshake between the sequencer and the rotator.
    typedef struct packed {
        logic start;
    } t_rot_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rot_stat;

endpackage

// File: hw/rtl/pafk_cordic.sv
// ----------------------------------------------------------------------------
// pafk_cordic
// Shared iterative rotator: turns (mag, 0) by an angle, one step per cycle.
// ----------------------------------------------------------------------------
module pafk_cordic import pafk_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_rot_ctrl                i_ctrl,
    input  logic signed [21:0]       i_mag,
    input  logic [AngleBits-1:0]     i_angle,
    output t_rot_stat                o_stat,
    output logic signed [DW-17:0]    o_cos,
    output logic signed [DW-17:0]    o_sin
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ITER = 3'b100
    } t_state;

    t_state                r_state;
    logic [StepBits-1:0]   r_step;
    logic signed [DW-1:0]  r_x, r_y;
    logic signed [32:0]    r_z;
    logic [31:0]           r_a;
    logic signed [21:0]    r_mag;
    logic                  r_done;

    logic [31:0]           w_a;
    logic                  w_flip;
    logic signed [DW-1:0]  w_prod;
    logic signed [DW-1:0]  w_dx, w_dy;
    logic [4:0]            w_idx;

    assign w_a    = 32'(i_angle) << (32 - AngleBits);
    assign w_flip = (r_a[31:30] == 2'd1) || (r_a[31:30] == 2'd2);
    assign w_prod = DW'(r_mag) * $signed({1'b0, InvGain});
    // >>> floors for signed values
    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_idx  = 5'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_mag   <= i_mag;
                        r_a     <= w_a;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_x     <= w_flip ? -(w_prod >>> 15) : (w_prod >>> 15);
                    r_y     <= '0;
                    r_z     <= w_flip ? 33'($signed(r_a + 32'h80000000))
                                      : 33'($signed(r_a));
                    r_step  <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - $signed({1'b0, atan_turn(w_idx)});
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + $signed({1'b0, atan_turn(w_idx)});
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == StepBits'(CordicSteps - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic signed [DW-1:0] w_xr, w_yr;
    assign w_xr = (r_x + DW'(32768)) >>> 16;
    assign w_yr = (r_y + DW'(32768)) >>> 16;
    assign o_cos = w_xr[DW-17:0];
    assign o_sin = w_yr[DW-17:0];
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = r_done;

endmodule

// File: hw/rtl/planar_arm_forward_kinematics_top.sv
// Each joint word is processed by two back-to-back rotations on the single shared
// rotator. The input is not ready until the result for the word has been loaded
// into the output register; a full output register stalls the sequencer.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, active low) clears state, config, running sums and counter.
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics_top
// Serial arm forward kinematics with a shared iterative rotator.
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics_top import pafk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] joint_angle
    input  logic        s_axis_tlast,  // last_joint
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata, // [3:0] joint_number, [19:4] absolute_angle,
                                       // [40:20] reach, [61:41] height,
                                       // [82:62] world_x, [103:83] world_y
    output logic        m_axis_tlast   // last_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_JOINT = 4'b0010,
        S_BASE  = 4'b0100,
        S_DONE  = 4'b1000
    } t_seq;

    t_seq                r_seq;
    logic [15:0]         r_link_length, r_base_rotation;
    logic [15:0]         r_angle;
    logic signed [21:0]  r_reach_run, r_height_run;
    logic [CntBits-1:0]  r_count;
    logic                r_last;
    logic                r_wait;   // rotation started, result pending
    logic                r_ovalid;
    logic [103:0]        r_odata;
    logic                r_olast;
    logic signed [20:0]  r_reach, r_height;

    t_rot_ctrl           w_ctrl;
    t_rot_stat           w_stat;
    logic signed [21:0]  w_mag;
    logic [15:0]         w_rot_angle;
    logic signed [DW-17:0] w_cos, w_sin;
    logic signed [DW-17:0] w_rsum, w_hsum;
    logic                w_in_acc;
    logic                w_out_load;

    // Saturate a wide value into 21 bits.
    function automatic logic signed [20:0] sat21(input logic signed [DW-17:0] v);
        if (v > (DW-16)'(OutMax)) return OutMax;
        if (v < (DW-16)'(OutMin)) return OutMin;
        return v[20:0];
    endfunction

    function automatic logic signed [21:0] sat22(input logic signed [DW-17:0] v);
        if (v > (DW-16)'(RunMax)) return RunMax;
        if (v < (DW-16)'(RunMin)) return RunMin;
        return v[21:0];
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_seq == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    // Load the output register once it is free or being drained this cycle.
    assign w_out_load    = (r_seq == S_DONE) && (!r_ovalid || m_axis_tready);

    // Start one rotation on entry to each rotation phase.
    assign w_ctrl.start  = !r_wait && ((r_seq == S_JOINT) || (r_seq == S_BASE));
    assign w_mag         = (r_seq == S_JOINT) ? $signed({6'd0, r_link_length})
                                              : 22'(r_reach);
    assign w_rot_angle   = (r_seq == S_JOINT) ? r_angle : r_base_rotation;
    assign w_rsum        = (DW-16)'(r_reach_run) + w_cos;
    assign w_hsum        = (DW-16)'(r_height_run) + w_sin;

    pafk_cordic u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_mag   (w_mag),
        .i_angle (w_rot_angle),
        .o_stat  (w_stat),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq           <= S_IDLE;
            r_link_length   <= '0;
            r_base_rotation <= '0;
            r_angle         <= '0;
            r_reach_run     <= '0;
            r_height_run    <= '0;
            r_count         <= '0;
            r_wait          <= 1'b0;
            r_ovalid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegLinkLength:   r_link_length   <= i_cfg_data;
                    RegBaseRotation: r_base_rotation <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_ctrl.start) r_wait <= 1'b1;
            unique case (r_seq)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_angle <= r_angle + s_axis_tdata;
                        r_last  <= s_axis_tlast;
                        r_seq   <= S_JOINT;
                    end
                end
                S_JOINT: begin
                    if (r_wait && w_stat.done) begin
                        r_wait       <= 1'b0;
                        r_reach_run  <= sat22(w_rsum);
                        r_height_run <= sat22(w_hsum);
                        r_reach      <= sat21((DW-16)'(sat22(w_rsum)));
                        r_height     <= sat21((DW-16)'(sat22(w_hsum)));
                        r_seq        <= S_BASE;
                    end
                end
                S_BASE: begin
                    if (r_wait && w_stat.done) begin
                        r_wait <= 1'b0;
                        r_seq  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free; the rotator keeps
                    // its last result meanwhile.
                    if (w_out_load) begin
                        r_odata <= {sat21(w_sin), sat21(w_cos), r_height, r_reach,
                                    r_angle, 4'(r_count)};
                        r_olast <= r_last;
                        if (r_last) begin
                            r_angle      <= '0;
                            r_reach_run  <= '0;
                            r_height_run <= '0;
                            r_count      <= '0;
                        end else begin
                            r_count <= (32'(r_count) + 1 >= MaxLinks) ? '0
                                                                      : r_count + 1'b1;
                        end
                        r_seq <= S_IDLE;
                    end
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_no_input_busy, i_clk, i_rst_n, w_stat.busy |-> !s_axis_tready, "ready while rotating")
    `ASSERT_CLK(a_done_needs_wait, i_clk, i_rst_n, (w_stat.done && r_seq != S_IDLE) |-> r_wait, "stray done")
    `ASSERT_ALWAYS(a_seq_onehot, i_clk, $onehot(r_seq) || !i_rst_n, "sequencer not one-hot")

endmodule
